// ----- rtl/xrle_pkg.sv -----
// Shared types and constants for the XBin run-length decoder.
// Used by xrle_ctrl, xrle_dp and xbin_rle_decoder_top; no dependencies.
package xrle_pkg;

  localparam logic [31:0] CELLS_RESET = 32'd2000;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_HOLD1,
    ST_HOLD2,
    ST_LIT_FIRST,
    ST_LIT_SECOND,
    ST_LIT_ONE,
    ST_DONE,
    ST_BURST
  } phase_t;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_CHAR,
    MODE_ATTR,
    MODE_BOTH
  } mode_t;

  typedef enum logic [1:0] {
    SEL_PAIR,
    SEL_CHAR_HELD,
    SEL_ATTR_HELD,
    SEL_BOTH
  } cell_sel_t;

  typedef struct packed {
    logic      reload;
    logic      load_hdr;
    logic      take_char;
    logic      take_attr;
    logic      take_pair;
    logic      emit;
    cell_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic  out_space;
    mode_t hdr_mode;
    mode_t run_mode;
    logic  cells_zero;
    logic  total_zero;
    logic  end_run;
    logic  end_image;
  } sts_t;

endpackage

// ----- rtl/xrle_ctrl.sv -----
// Decode phase state machine for the XBin run-length decoder.
// Depends on xrle_pkg; drives commands into xrle_dp from its status.
module xrle_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tuser,
  output logic          in_tready,
  input  xrle_pkg::sts_t st,
  output xrle_pkg::cmd_t cmd
);
  import xrle_pkg::*;

  phase_t state_r;
  phase_t state_nxt;
  phase_t phase_eff;
  logic   accept;
  logic   zero_eff;

  function automatic phase_t after_cell(sts_t s, phase_t cont);
    phase_t p;
    if (s.end_image) begin
      p = ST_DONE;
    end else if (s.end_run) begin
      p = ST_HEADER;
    end else begin
      p = cont;
    end
    return p;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HEADER;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r != ST_BURST) && st.out_space;
  assign accept    = in_tvalid && in_tready;
  assign phase_eff = in_tuser ? ST_HEADER : state_r;
  assign zero_eff  = in_tuser ? st.total_zero : st.cells_zero;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_PAIR;
    if (accept) begin
      cmd.reload = in_tuser;
      case (phase_eff)
        ST_HEADER: begin
          if (zero_eff) begin
            state_nxt = ST_DONE;
          end else begin
            cmd.load_hdr = 1'b1;
            state_nxt    = (st.hdr_mode == MODE_NONE) ? ST_LIT_FIRST : ST_HOLD1;
          end
        end
        ST_HOLD1: begin
          case (st.run_mode)
            MODE_CHAR: begin
              cmd.take_char = 1'b1;
              state_nxt     = ST_LIT_ONE;
            end
            MODE_ATTR: begin
              cmd.take_attr = 1'b1;
              state_nxt     = ST_LIT_ONE;
            end
            MODE_BOTH: begin
              cmd.take_char = 1'b1;
              state_nxt     = ST_HOLD2;
            end
            default: begin
              state_nxt = ST_HEADER;
            end
          endcase
        end
        ST_HOLD2: begin
          cmd.take_attr = 1'b1;
          state_nxt     = ST_BURST;
        end
        ST_LIT_FIRST: begin
          cmd.take_pair = 1'b1;
          state_nxt     = ST_LIT_SECOND;
        end
        ST_LIT_SECOND: begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_PAIR;
          state_nxt = after_cell(st, ST_LIT_FIRST);
        end
        ST_LIT_ONE: begin
          cmd.emit  = 1'b1;
          cmd.sel   = (st.run_mode == MODE_CHAR) ? SEL_CHAR_HELD : SEL_ATTR_HELD;
          state_nxt = after_cell(st, ST_LIT_ONE);
        end
        ST_DONE: begin
          state_nxt = ST_DONE;
        end
        default: begin
          state_nxt = ST_HEADER;
        end
      endcase
    end else if (state_r == ST_BURST && st.out_space) begin
      cmd.emit  = 1'b1;
      cmd.sel   = SEL_BOTH;
      state_nxt = after_cell(st, ST_BURST);
    end
  end

`ifndef SYNTHESIS
  a_emit_space: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_space)
    else $error("cell emitted while output register is blocked");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !(accept && in_tuser)) |=> state_r == ST_DONE)
    else $error("left image-done without a restart");

  a_burst_cells: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BURST |-> !st.cells_zero && !in_tready)
    else $error("burst with no cells left or input open");

  a_image_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && st.end_image) |=> state_r == ST_DONE)
    else $error("last image cell did not end decoding");
`endif

endmodule

// ----- rtl/xrle_dp.sv -----
// Datapath of the XBin run-length decoder: counters, held bytes, output register.
// Depends on xrle_pkg; controlled by xrle_ctrl through cmd_t and sts_t.
module xrle_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata,
  input  logic [7:0]           in_data,
  input  xrle_pkg::cmd_t       cmd,
  output xrle_pkg::sts_t       st,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,
  output logic                 out_tlast,
  output logic [1:0]           out_tuser
);
  import xrle_pkg::*;

  logic [31:0] total_r;
  logic [31:0] cells_left_r;
  mode_t       run_mode_r;
  logic [6:0]  run_left_r;
  logic [7:0]  held_char_r;
  logic [7:0]  held_attr_r;
  logic [7:0]  pair_r;
  logic        out_valid_r;
  logic [7:0]  out_char_r;
  logic [7:0]  out_attr_r;
  logic        out_last_r;
  logic        out_done_r;
  logic        out_ovr_r;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;

  assign st.out_space  = !out_valid_r || out_tready;
  assign st.hdr_mode   = mode_t'(in_data[7:6]);
  assign st.run_mode   = run_mode_r;
  assign st.cells_zero = (cells_left_r == 32'd0);
  assign st.total_zero = (total_r == 32'd0);
  assign st.end_run    = (run_left_r == 7'd1);
  assign st.end_image  = (cells_left_r == 32'd1);

  always_comb begin
    case (cmd.sel)
      SEL_PAIR: begin
        cell_char = pair_r;
        cell_attr = in_data;
      end
      SEL_CHAR_HELD: begin
        cell_char = held_char_r;
        cell_attr = in_data;
      end
      SEL_ATTR_HELD: begin
        cell_char = in_data;
        cell_attr = held_attr_r;
      end
      default: begin
        cell_char = held_char_r;
        cell_attr = held_attr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= CELLS_RESET;
    end else if (cfg_we) begin
      total_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_left_r <= CELLS_RESET;
      run_mode_r   <= MODE_NONE;
      run_left_r   <= 7'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.emit) begin
        cells_left_r <= cells_left_r - 32'd1;
        run_left_r   <= run_left_r - 7'd1;
      end else begin
        if (cmd.reload) begin
          cells_left_r <= total_r;
        end
        if (cmd.load_hdr) begin
          run_mode_r <= mode_t'(in_data[7:6]);
          run_left_r <= {1'b0, in_data[5:0]} + 7'd1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_char) begin
      held_char_r <= in_data;
    end
    if (cmd.take_attr) begin
      held_attr_r <= in_data;
    end
    if (cmd.take_pair) begin
      pair_r <= in_data;
    end
    if (cmd.emit) begin
      out_char_r <= cell_char;
      out_attr_r <= cell_attr;
      out_last_r <= (cmd.sel != SEL_BOTH) || st.end_run || st.end_image;
      out_done_r <= st.end_image;
      out_ovr_r  <= st.end_image && !st.end_run;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_attr_r, out_char_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovr_r, out_done_r};

endmodule

// ----- rtl/xbin_rle_decoder_top.sv -----
// XBin run-length decoder: takes one compressed byte per transaction and
// returns character/attribute cells. Header, held and first-of-pair bytes
// yield no cell; every other byte yields one cell, and the attribute byte of
// a both-repeat run yields the whole run. Input is taken at one byte per
// cycle while the single output register drains; a both-repeat run closes
// the input while the burst counter emits one cell per cycle whenever the
// output register has space. total_cells is reloaded into the cell counter
// on start_of_image. Top level; depends on xrle_pkg, xrle_ctrl and xrle_dp.
module xbin_rle_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,   // total_cells
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tuser,    // [0] start_of_image
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] char_code, [15:8] attribute
  output logic        out_tlast,   // last cell produced by the current input byte
  output logic [1:0]  out_tuser    // [0] image_done, [1] overrun_error
);
  import xrle_pkg::*;

  cmd_t cmd;
  sts_t st;

  xrle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  xrle_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_data    (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for xbin_rle_decoder_top: drives compressed XBin bytes and
// checks every decoded cell against an in-bench decoder model or a directed table.
// Depends on xrle_pkg and xbin_rle_decoder_top.
`timescale 1ns / 1ps

module tb_top;
  import xrle_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int TAIL_CYCLES = 80;
  localparam int DRAIN_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] at;
    logic       last;
    logic       done;
    logic       ovr;
  } cell_t;

  typedef struct packed {
    bit    fixed;
    bit    has;
    cell_t c;
  } offer_t;

  typedef struct packed {
    bit          wr;
    logic [31:0] val;
    logic [7:0]  b;
    bit          sof;
    bit          fixed;
    bit          has;
    cell_t       c;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  xbin_rle_decoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // decoder model state
  logic [31:0] img_total;
  phase_t      dec_phase;
  mode_t       dec_mode;
  logic [6:0]  run_due;
  logic [7:0]  held_ch;
  logic [7:0]  held_at;
  logic [7:0]  pair_ch;
  logic [31:0] cells_due;

  cell_t  step_cells[$];
  cell_t  pending_cells[$];
  offer_t offered_bytes[$];
  row_t   dir_rows[$];

  int errors = 0;
  int n_in = 0;
  int n_cells = 0;
  int n_cfg = 0;
  int cyc = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit start_img = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cyc);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic reset_decoder();
    img_total = CELLS_RESET;
    dec_phase = ST_HEADER;
    dec_mode  = MODE_NONE;
    run_due   = '0;
    held_ch   = '0;
    held_at   = '0;
    pair_ch   = '0;
    cells_due = CELLS_RESET;
  endtask

  task automatic emit_cell(input logic [7:0] ch, input logic [7:0] at);
    cell_t c;
    if (run_due != 0) run_due = run_due - 7'd1;
    if (cells_due != 0) cells_due = cells_due - 32'd1;
    c.ch   = ch;
    c.at   = at;
    c.last = 1'b0;
    c.done = (cells_due == 0);
    c.ovr  = (cells_due == 0) && (run_due != 0);
    step_cells.push_back(c);
  endtask

  task automatic next_phase(input phase_t cont);
    if (cells_due == 0) dec_phase = ST_DONE;
    else if (run_due == 0) dec_phase = ST_HEADER;
    else dec_phase = cont;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic sof);
    step_cells.delete();
    if (sof) begin
      cells_due = img_total;
      dec_phase = ST_HEADER;
    end
    case (dec_phase)
      ST_HEADER: begin
        if (cells_due == 0) begin
          dec_phase = ST_DONE;
        end else begin
          dec_mode = mode_t'(b[7:6]);
          run_due  = {1'b0, b[5:0]} + 7'd1;
          if (dec_mode == MODE_NONE) dec_phase = ST_LIT_FIRST;
          else dec_phase = ST_HOLD1;
        end
      end
      ST_HOLD1: begin
        case (dec_mode)
          MODE_CHAR: begin
            held_ch   = b;
            dec_phase = ST_LIT_ONE;
          end
          MODE_ATTR: begin
            held_at   = b;
            dec_phase = ST_LIT_ONE;
          end
          MODE_BOTH: begin
            held_ch   = b;
            dec_phase = ST_HOLD2;
          end
          default: dec_phase = ST_HEADER;
        endcase
      end
      ST_HOLD2: begin
        held_at = b;
        while (run_due != 0 && cells_due != 0) emit_cell(held_ch, held_at);
        next_phase(ST_HEADER);
      end
      ST_LIT_FIRST: begin
        pair_ch   = b;
        dec_phase = ST_LIT_SECOND;
      end
      ST_LIT_SECOND: begin
        emit_cell(pair_ch, b);
        next_phase(ST_LIT_FIRST);
      end
      ST_LIT_ONE: begin
        if (dec_mode == MODE_CHAR) emit_cell(held_ch, b);
        else emit_cell(b, held_at);
        next_phase(ST_LIT_ONE);
      end
      ST_DONE: ;
      default: dec_phase = ST_HEADER;
    endcase
    if (step_cells.size() > 0) step_cells[step_cells.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin : predict_mon
    offer_t o;
    if (rst_n) begin
      if (cfg_we) img_total = cfg_wdata;
      if (in_tvalid && in_tready) begin
        o = offered_bytes.pop_front();
        decode_byte(in_tdata, in_tuser);
        if (o.fixed) begin
          if (o.has) pending_cells.push_back(o.c);
        end else begin
          foreach (step_cells[i]) pending_cells.push_back(step_cells[i]);
        end
        n_in++;
      end
    end
  end

  always @(posedge clk) begin : cell_mon
    cell_t got;
    cell_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ch   = out_tdata[7:0];
      got.at   = out_tdata[15:8];
      got.last = out_tlast;
      got.done = out_tuser[0];
      got.ovr  = out_tuser[1];
      n_cells++;
      if (pending_cells.size() == 0) begin
        $display("%0t: unexpected cell ch=%02h at=%02h last=%b done=%b ovr=%b",
                 $time, got.ch, got.at, got.last, got.done, got.ovr);
        errors++;
      end else begin
        want = pending_cells.pop_front();
        if (got !== want) begin
          $display("%0t: cell mismatch: expected ch=%02h at=%02h last=%b done=%b ovr=%b,",
                   $time, want.ch, want.at, want.last, want.done, want.ovr);
          $display("%0t:   actual ch=%02h at=%02h last=%b done=%b ovr=%b",
                   $time, got.ch, got.at, got.last, got.done, got.ovr);
          errors++;
        end
      end
    end
  end

  initial begin : sink
    int n;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 14);
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  function automatic row_t r_byte(input logic [7:0] b, input bit sof);
    row_t r;
    r     = '0;
    r.b   = b;
    r.sof = sof;
    return r;
  endfunction

  function automatic row_t r_none(input logic [7:0] b, input bit sof);
    row_t r;
    r       = r_byte(b, sof);
    r.fixed = 1'b1;
    return r;
  endfunction

  function automatic row_t r_cell(input logic [7:0] b, input bit sof, input logic [7:0] ch,
                                  input logic [7:0] at, input bit last, input bit done,
                                  input bit ovr);
    row_t r;
    r     = r_none(b, sof);
    r.has = 1'b1;
    r.c   = '{ch: ch, at: at, last: last, done: done, ovr: ovr};
    return r;
  endfunction

  function automatic row_t r_cfg(input logic [31:0] v);
    row_t r;
    r     = '0;
    r.wr  = 1'b1;
    r.val = v;
    return r;
  endfunction

  task automatic drive_item(input logic [7:0] b, input bit sof, input bit fixed,
                            input bit has, input cell_t c);
    offer_t o;
    int gap;
    o.fixed = fixed;
    o.has   = has;
    o.c     = c;
    offered_bytes.push_back(o);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= sof;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    int w;
    w = 0;
    @(posedge clk);
    while (pending_cells.size() != 0 && w < DRAIN_LIMIT) begin
      @(posedge clk);
      w++;
    end
    if (pending_cells.size() != 0) begin
      $display("%0t: %0d expected cells never arrived", $time, pending_cells.size());
      errors++;
      pending_cells.delete();
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_cfg++;
  endtask

  task automatic send_packet(input int mode_req, inout int sent);
    int md;
    int len;
    int pay;
    bit sof;
    logic [7:0] hdr;
    if ($urandom_range(0, 9) == 0) begin
      drive_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0), 1'b0, 1'b0, '0);
      return;
    end
    md  = (mode_req >= 0) ? mode_req : $urandom_range(0, 3);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
    if (cells_due == 0) start_img = 1'b1;
    sof = start_img || ($urandom_range(0, 15) == 0);
    start_img = 1'b0;
    hdr = {md[1:0], len[5:0]};
    if (md == int'(MODE_NONE)) pay = 2 * (len + 1);
    else if (md == int'(MODE_BOTH)) pay = 2;
    else pay = len + 2;
    if ($urandom_range(0, 19) == 0) pay = $urandom_range(0, pay - 1);
    drive_item(hdr, sof, 1'b0, 1'b0, '0);
    sent++;
    repeat (pay) begin
      drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
      sent++;
    end
  endtask

  task automatic run_phase(input logic [31:0] total, input int nbytes, input int n_both,
                           input bit hold);
    int sent;
    int k;
    bit paused;
    settle();
    write_total(total);
    if (hold) hold_req = 1'b1;
    start_img = 1'b1;
    sent   = 0;
    k      = 0;
    paused = 1'b0;
    while (sent < nbytes) begin
      send_packet((k < n_both) ? int'(MODE_BOTH) : -1, sent);
      k++;
      if (!paused && sent >= nbytes / 2) begin
        in_tvalid <= 1'b0;
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    reset_decoder();
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    dir_rows = '{
      r_none(8'h00, 1'b1),
      r_none(8'h00, 1'b0),
      r_cell(8'hFF, 1'b0, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0),
      r_none(8'h41, 1'b0),
      r_none(8'hFF, 1'b0),
      r_cell(8'h00, 1'b0, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0),
      r_cell(8'hA5, 1'b0, 8'hFF, 8'hA5, 1'b1, 1'b0, 1'b0),
      r_none(8'h80, 1'b0),
      r_none(8'h5A, 1'b0),
      r_cell(8'hC3, 1'b0, 8'hC3, 8'h5A, 1'b1, 1'b0, 1'b0),
      r_none(8'hFF, 1'b0),
      r_none(8'h12, 1'b0),
      r_byte(8'h34, 1'b0),
      r_none(8'hC0, 1'b0),
      r_none(8'hAA, 1'b0),
      r_cell(8'h55, 1'b0, 8'hAA, 8'h55, 1'b1, 1'b0, 1'b0),
      r_none(8'h42, 1'b0),
      r_none(8'h99, 1'b0),
      r_byte(8'h01, 1'b0),
      r_none(8'h01, 1'b1),
      r_byte(8'h02, 1'b0),
      r_byte(8'h03, 1'b0),
      r_cfg(32'd3),
      r_none(8'hC4, 1'b1),
      r_none(8'h01, 1'b0),
      r_byte(8'h02, 1'b0),
      r_none(8'h77, 1'b0),
      r_none(8'hC0, 1'b0),
      r_cfg(32'd0),
      r_none(8'h00, 1'b1),
      r_none(8'h11, 1'b0),
      r_cfg(32'd1),
      r_none(8'h3F, 1'b1),
      r_none(8'hEE, 1'b0),
      r_cell(8'hDD, 1'b0, 8'hEE, 8'hDD, 1'b1, 1'b1, 1'b1)
    };
    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) begin
        settle();
        write_total(dir_rows[i].val);
      end else begin
        drive_item(dir_rows[i].b, dir_rows[i].sof, dir_rows[i].fixed, dir_rows[i].has,
                   dir_rows[i].c);
      end
    end

    run_phase(32'hFFFE_0001, 12, 4, 1'b1);
    run_phase(32'h0001_FFFF, 12, 0, 1'b0);
    run_phase(32'd25, 12, 0, 1'b0);
    run_phase(32'd1, 10, 0, 1'b0);
    idle_on = 1'b0;
    run_phase(32'd2000, 12, 0, 1'b0);
    settle();

    $display("Run covered %0d input bytes and %0d decoded cells", n_in, n_cells);
    $display("across %0d cell-total settings, all four run modes, cutoff and restart", n_cfg);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/xrle_pkg.sv
rtl/xrle_ctrl.sv
rtl/xrle_dp.sv
rtl/xbin_rle_decoder_top.sv
bench/tb_top.sv
